>>> src/bitmap_block_allocator_core_defines.svh
// assertion macros shared by the allocator rtl
`ifndef BITMAP_BLOCK_ALLOCATOR_CORE_DEFINES_SVH
`define BITMAP_BLOCK_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define BBA_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("allocator check failed (same cycle)");

// next-cycle implication, sampled on clk, off while arst_n is low
`define BBA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("allocator check failed (next cycle)");

`endif

>>> src/bba_pkg.sv
`timescale 1ns / 1ps

package bba_pkg;

	localparam int BN_W  = 14;
	localparam int CNT_W = 15;
	localparam int CFG_W = 15;

	typedef enum logic [1:0] {
		CMD_ALLOC = 2'd0,
		CMD_FREE  = 2'd1,
		CMD_TEST  = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef enum logic [0:0] {
		CFG_FIRST_DATA_BLOCK = 1'b0,
		CFG_BLOCK_COUNT      = 1'b1
	} cfg_idx_t;

	typedef enum logic [5:0] {
		S_CLR  = 6'b000001,
		S_IDLE = 6'b000010,
		S_DIVA = 6'b000100,
		S_DIVB = 6'b001000,
		S_SCAN = 6'b010000,
		S_RESP = 6'b100000
	} state_t;

endpackage

>>> src/bba_ram.sv
`timescale 1ns / 1ps

module bba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> src/bba_div.sv
`timescale 1ns / 1ps

// two-stage split of a block number into word, bit offset and word base
module bba_div #(
	parameter int WORD_BITS = 32
) (
	input  logic                           clk,
	input  logic                           start,
	input  logic [bba_pkg::BN_W-1:0]       value,
	output logic [bba_pkg::BN_W-1:0]       quotient,
	output logic [$clog2(WORD_BITS)-1:0]   remainder,
	output logic [bba_pkg::BN_W-1:0]       base
);

	localparam int OFF_W  = $clog2(WORD_BITS);
	localparam int SH     = bba_pkg::BN_W + 7;
	localparam int PROD_W = SH + bba_pkg::BN_W;
	localparam logic [PROD_W-1:0] RECIP = PROD_W'((64'd1 << SH) / WORD_BITS);
	localparam logic [bba_pkg::BN_W-1:0] STEP = bba_pkg::BN_W'(WORD_BITS);

	logic [PROD_W-1:0]        prod;
	logic [bba_pkg::BN_W-1:0] q_est_s1;
	logic [bba_pkg::BN_W-1:0] value_s1;
	logic [bba_pkg::BN_W-1:0] back;
	logic [bba_pkg::BN_W-1:0] diff;
	logic [bba_pkg::BN_W-1:0] rem_full;
	logic                     fix;
	logic [bba_pkg::BN_W-1:0] quot_s2;
	logic [OFF_W-1:0]         rem_s2;
	logic [bba_pkg::BN_W-1:0] base_s2;

	// floored reciprocal: estimate is exact or one low
	assign prod = PROD_W'(value) * RECIP;

	always_ff @(posedge clk) begin
		if (start) begin
			q_est_s1 <= prod[SH +: bba_pkg::BN_W];
			value_s1 <= value;
		end
	end

	assign back     = bba_pkg::BN_W'(q_est_s1 * STEP);
	assign diff     = value_s1 - back;
	assign fix      = (diff >= STEP);
	assign rem_full = fix ? (diff - STEP) : diff;

	always_ff @(posedge clk) begin
		quot_s2 <= fix ? (q_est_s1 + bba_pkg::BN_W'(1)) : q_est_s1;
		rem_s2  <= rem_full[OFF_W-1:0];
		base_s2 <= fix ? (back + STEP) : back;
	end

	assign quotient  = quot_s2;
	assign remainder = rem_s2;
	assign base      = base_s2;

endmodule

>>> src/bitmap_block_allocator_core.sv
`timescale 1ns / 1ps
`include "bitmap_block_allocator_core_defines.svh"

// channel   direction  handshake             payload
// cfg       in         cfg_wr_en             cfg_index, cfg_data
// request   in         in_valid / in_ready   command, block_number
// result    out        out_valid / out_ready result_block, block_used, status
//
// free and test: two divide stages, one word read, then the result
// allocate: two divide stages, then one ram read per bitmap word scanned, then the result
// out-of-range free or test and an empty allocate window skip the read
// after reset a clearing pass writes zeros to all MAP_WORDS words (512 words by default)
// in_ready is low while a request is in flight or the clearing pass runs
// a finished result sits in the output register; the next request is taken meanwhile
module bitmap_block_allocator_core #(
	parameter int MAX_BLOCKS = 16384,
	parameter int WORD_BITS  = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [0:0]                cfg_index,
	input  logic [bba_pkg::CFG_W-1:0] cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [1:0]                command,
	input  logic [bba_pkg::BN_W-1:0]  block_number,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [bba_pkg::BN_W-1:0]  result_block,
	output logic                      block_used,
	output logic [1:0]                status
);

	localparam int MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
	localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int OFF_W     = $clog2(WORD_BITS);
	localparam int BN_W      = bba_pkg::BN_W;
	localparam int CNT_W     = bba_pkg::CNT_W;
	localparam logic [AW-1:0]    LAST_WORD = AW'(MAP_WORDS - 1);
	localparam logic [16:0]      MAX_LIM   = 17'(MAX_BLOCKS);
	localparam logic [CNT_W-1:0] WORD_STEP = CNT_W'(WORD_BITS);

	// control state
	bba_pkg::state_t state_q;
	logic [AW-1:0]   clr_cnt_q;
	logic            out_valid_q;
	logic [BN_W-1:0] first_data_block_q;
	logic [CNT_W-1:0] block_count_q;

	// per-request payload
	logic [1:0]       cmd_q;
	logic [BN_W-1:0]  blk_q;
	logic             in_range_q;
	logic [AW-1:0]    word_q;
	logic [OFF_W-1:0] off_q;
	logic [CNT_W-1:0] base_q;
	logic [CNT_W-1:0] lim_q;
	logic             first_q;
	logic [BN_W-1:0]  res_block_q;
	logic             res_used_q;
	bba_pkg::status_t res_status_q;
	logic [BN_W-1:0]  result_block_q;
	logic             block_used_q;
	bba_pkg::status_t status_q;

	logic             in_acc;
	logic             out_free;
	logic [CNT_W-1:0] n_eff;
	logic             fdb_ok;
	logic [BN_W-1:0]  div_value;
	logic [BN_W-1:0]  div_quot;
	logic [OFF_W-1:0] div_rem;
	logic [BN_W-1:0]  div_base;

	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [WORD_BITS-1:0] ram_wdata;
	logic [AW-1:0]        ram_raddr;
	logic [WORD_BITS-1:0] ram_rdata;

	logic [WORD_BITS-1:0] avail;
	logic                 hit;
	logic [OFF_W-1:0]     idx;
	logic [WORD_BITS-1:0] set_mask;
	logic [WORD_BITS-1:0] off_mask;

	// bitmap write during a scan, and commands allowed to write
	logic                 scan_wr;
	logic                 cmd_writes;

	assign in_ready = (state_q == bba_pkg::S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// block count, limited to the bitmap size
	assign n_eff  = (17'(block_count_q) > MAX_LIM) ? MAX_LIM[CNT_W-1:0] : block_count_q;
	assign fdb_ok = (CNT_W'(first_data_block_q) < n_eff);

	// allocate starts its scan at first_data_block, free and test go to the block itself
	assign div_value = (command == bba_pkg::CMD_ALLOC) ? first_data_block_q : block_number;

	bba_div #(
		.WORD_BITS (WORD_BITS)
	) u_div (
		.clk       (clk),
		.start     (in_acc),
		.value     (div_value),
		.quotient  (div_quot),
		.remainder (div_rem),
		.base      (div_base)
	);

	bba_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (MAP_WORDS)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// free bits of the current word inside the allocation window
	always_comb begin
		for (int i = 0; i < WORD_BITS; i++) begin
			avail[i] = !ram_rdata[i]
				&& !(first_q && (OFF_W'(i) < off_q))
				&& (lim_q > CNT_W'(i));
		end
	end

	// lowest free bit
	always_comb begin
		idx = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (avail[i]) begin
				idx = OFF_W'(i);
			end
		end
	end

	assign hit      = |avail;
	assign set_mask = WORD_BITS'(1) << idx;
	assign off_mask = WORD_BITS'(1) << off_q;

	// first word comes from the divider, later words are fetched one ahead
	assign ram_raddr = (state_q == bba_pkg::S_DIVB) ? div_quot[AW-1:0] : (word_q + AW'(1));

	// bitmap writes: clearing pass, set on allocate, clear on free
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = word_q;
		ram_wdata = ram_rdata | set_mask;
		case (state_q)
			bba_pkg::S_CLR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_cnt_q;
				ram_wdata = '0;
			end
			bba_pkg::S_SCAN: begin
				if (cmd_q == bba_pkg::CMD_ALLOC) begin
					ram_we = hit;
				end else if (cmd_q == bba_pkg::CMD_FREE) begin
					ram_we    = 1'b1;
					ram_wdata = ram_rdata & ~off_mask;
				end
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	assign scan_wr    = (state_q == bba_pkg::S_SCAN) && ram_we;
	assign cmd_writes = (cmd_q == bba_pkg::CMD_ALLOC) || (cmd_q == bba_pkg::CMD_FREE);

	// sequencer and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q            <= bba_pkg::S_CLR;
			clr_cnt_q          <= '0;
			out_valid_q        <= 1'b0;
			first_data_block_q <= BN_W'(108);
			block_count_q      <= CNT_W'(16384);
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					bba_pkg::CFG_FIRST_DATA_BLOCK: first_data_block_q <= cfg_data[BN_W-1:0];
					bba_pkg::CFG_BLOCK_COUNT:      block_count_q      <= cfg_data[CNT_W-1:0];
					default:                       block_count_q      <= block_count_q;
				endcase
			end
			// a new result may replace the one leaving in the same cycle
			if ((state_q == bba_pkg::S_RESP) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				bba_pkg::S_CLR: begin
					clr_cnt_q <= clr_cnt_q + AW'(1);
					if (clr_cnt_q == LAST_WORD) begin
						state_q <= bba_pkg::S_IDLE;
					end
				end
				bba_pkg::S_IDLE: begin
					if (in_valid) begin
						state_q <= bba_pkg::S_DIVA;
					end
				end
				bba_pkg::S_DIVA: begin
					state_q <= bba_pkg::S_DIVB;
				end
				bba_pkg::S_DIVB: begin
					// empty window or out-of-range block skips the read
					if (cmd_q == bba_pkg::CMD_ALLOC) begin
						state_q <= fdb_ok ? bba_pkg::S_SCAN : bba_pkg::S_RESP;
					end else begin
						state_q <= in_range_q ? bba_pkg::S_SCAN : bba_pkg::S_RESP;
					end
				end
				bba_pkg::S_SCAN: begin
					if (!((cmd_q == bba_pkg::CMD_ALLOC) && !hit && (lim_q > WORD_STEP))) begin
						state_q <= bba_pkg::S_RESP;
					end
				end
				bba_pkg::S_RESP: begin
					if (out_free) begin
						state_q <= bba_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= bba_pkg::S_IDLE;
				end
			endcase
		end
	end

	// request payload, scan position and result
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q      <= command;
			blk_q      <= block_number;
			in_range_q <= (CNT_W'(block_number) < n_eff);
		end
		case (state_q)
			bba_pkg::S_DIVB: begin
				word_q  <= div_quot[AW-1:0];
				off_q   <= div_rem;
				base_q  <= CNT_W'(div_base);
				lim_q   <= n_eff - CNT_W'(div_base);
				first_q <= 1'b1;
				// default outcome: no free block, or block out of range
				res_used_q <= 1'b0;
				if (cmd_q == bba_pkg::CMD_ALLOC) begin
					res_block_q  <= '0;
					res_status_q <= bba_pkg::ST_FULL;
				end else begin
					res_block_q  <= blk_q;
					res_status_q <= bba_pkg::ST_RANGE;
				end
			end
			bba_pkg::S_SCAN: begin
				case (cmd_q)
					bba_pkg::CMD_ALLOC: begin
						if (hit) begin
							res_block_q  <= BN_W'(base_q + CNT_W'(idx));
							res_used_q   <= 1'b1;
							res_status_q <= bba_pkg::ST_OK;
						end else if (lim_q > WORD_STEP) begin
							word_q  <= word_q + AW'(1);
							base_q  <= base_q + WORD_STEP;
							lim_q   <= lim_q - WORD_STEP;
							first_q <= 1'b0;
						end
					end
					bba_pkg::CMD_FREE: begin
						res_used_q   <= 1'b0;
						res_status_q <= bba_pkg::ST_OK;
					end
					default: begin
						// test, and the unused code, read the bit only
						res_used_q   <= ram_rdata[off_q];
						res_status_q <= bba_pkg::ST_OK;
					end
				endcase
			end
			bba_pkg::S_RESP: begin
				if (out_free) begin
					result_block_q <= res_block_q;
					block_used_q   <= res_used_q;
					status_q       <= res_status_q;
				end
			end
			default: begin
				first_q <= first_q;
			end
		endcase
	end

	assign out_valid    = out_valid_q;
	assign result_block = result_block_q;
	assign block_used   = block_used_q;
	assign status       = status_q;

	// a request always enters the divider first
	`BBA_ASSERT_NEXT(a_accept_starts_divide, in_valid && in_ready, state_q == bba_pkg::S_DIVA)
	// a bitmap update finishes the request
	`BBA_ASSERT_NEXT(a_write_ends_scan, scan_wr, state_q == bba_pkg::S_RESP)
	// only allocate and free touch the bitmap during a scan
	`BBA_ASSERT_IMPL(a_write_by_cmd, scan_wr, cmd_writes)
	// a result only appears out of the result state
	`BBA_ASSERT_IMPL(a_result_from_resp, $rose(out_valid_q), $past(state_q == bba_pkg::S_RESP))

endmodule

>>> tb/bba_checker.sv
`timescale 1ns / 1ps

// watches config writes, requests and results; keeps its own copy of the used map
module bba_checker #(
	parameter int MAX_BLOCKS = 16384,
	parameter int WORD_BITS  = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [0:0]                cfg_index,
	input  logic [bba_pkg::CFG_W-1:0] cfg_data,
	input  logic                      in_valid,
	input  logic                      in_ready,
	input  logic [1:0]                command,
	input  logic [bba_pkg::BN_W-1:0]  block_number,
	input  logic                      out_valid,
	input  logic                      out_ready,
	input  logic [bba_pkg::BN_W-1:0]  result_block,
	input  logic                      block_used,
	input  logic [1:0]                status,
	output int                        fail_count,
	output int                        pending,
	output int                        checked
);

	localparam int BN_W  = bba_pkg::BN_W;
	localparam int CNT_W = bba_pkg::CNT_W;
	localparam int MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
	localparam logic [BN_W-1:0]  RESET_FIRST_BLOCK = 14'd108;
	localparam logic [CNT_W-1:0] RESET_BLOCK_COUNT = 15'd16384;

	typedef struct packed {
		logic [BN_W-1:0]  blk;
		logic             used;
		bba_pkg::status_t st;
	} alloc_result_t;

	logic [WORD_BITS-1:0] used_map [MAP_WORDS];
	logic [BN_W-1:0]      first_block;
	logic [CNT_W-1:0]     block_limit;
	alloc_result_t        expected_q [$];

	// first-fit allocate, free, test; updates the local used map
	function automatic alloc_result_t predict_request(logic [1:0] cmd, logic [BN_W-1:0] blk);
		int unsigned   n;
		alloc_result_t r;
		n     = (block_limit > MAX_BLOCKS) ? MAX_BLOCKS : block_limit;
		r.blk  = blk;
		r.used = 1'b0;
		r.st   = bba_pkg::ST_OK;
		case (cmd)
			bba_pkg::CMD_ALLOC: begin
				r.blk = '0;
				r.st  = bba_pkg::ST_FULL;
				for (int unsigned b = first_block; b < n; b++) begin
					if (!used_map[b / WORD_BITS][b % WORD_BITS]) begin
						used_map[b / WORD_BITS][b % WORD_BITS] = 1'b1;
						r.blk  = BN_W'(b);
						r.used = 1'b1;
						r.st   = bba_pkg::ST_OK;
						break;
					end
				end
			end
			bba_pkg::CMD_FREE: begin
				if (blk < n)
					used_map[blk / WORD_BITS][blk % WORD_BITS] = 1'b0;
				else
					r.st = bba_pkg::ST_RANGE;
			end
			default: begin
				// test, and the unused code behaves as test
				if (blk < n)
					r.used = used_map[blk / WORD_BITS][blk % WORD_BITS];
				else
					r.st = bba_pkg::ST_RANGE;
			end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		alloc_result_t want;
		int            errors;
		errors = 0;
		if (!arst_n) begin
			for (int w = 0; w < MAP_WORDS; w++)
				used_map[w] = '0;
			first_block = RESET_FIRST_BLOCK;
			block_limit = RESET_BLOCK_COUNT;
			expected_q.delete();
			pending    <= 0;
			fail_count <= 0;
			checked    <= 0;
		end else begin
			// results first: a result leaving now belongs to an older request
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result block %0d used %0b status %0d",
						$time, result_block, block_used, status);
					errors++;
				end else begin
					want = expected_q.pop_front();
					if (result_block !== want.blk) begin
						$display("%0t: result_block expected %0d actual %0d",
							$time, want.blk, result_block);
						errors++;
					end
					if (block_used !== want.used) begin
						$display("%0t: block_used expected %0b actual %0b",
							$time, want.used, block_used);
						errors++;
					end
					if (status !== want.st) begin
						$display("%0t: status expected %0d actual %0d",
							$time, want.st, status);
						errors++;
					end
					checked <= checked + 1;
				end
			end
			if (in_valid && in_ready)
				expected_q.push_back(predict_request(command, block_number));
			if (cfg_wr_en) begin
				case (bba_pkg::cfg_idx_t'(cfg_index))
					bba_pkg::CFG_FIRST_DATA_BLOCK: first_block = cfg_data[BN_W-1:0];
					bba_pkg::CFG_BLOCK_COUNT:      block_limit = cfg_data[CNT_W-1:0];
					default: ;
				endcase
			end
			fail_count <= fail_count + errors;
			pending    <= expected_q.size();
		end
	end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

// top: drives requests and config writes into the allocator, the checker does
// the prediction and comparison, this module decides pass or fail
module testbench;

	localparam int BN_W  = bba_pkg::BN_W;
	localparam int CFG_W = bba_pkg::CFG_W;

	// raw command code outside the enum, block treats it as a test
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam int MAX_BLOCKS        = 16384;
	localparam int ITEMS_PER_SETTING = 200;
	localparam int NUM_SETTINGS      = 9;
	// cycles with no request or result accepted before giving up; covers the
	// clearing pass after reset, a full-map scan and long receiver stalls
	localparam int STALL_LIMIT       = 20000;
	localparam int DRAIN_CYCLES      = 16;

	// idle plans: sender 33 / receiver 80, then swapped, then no idling
	localparam int TX_IDLE [3] = '{33, 80, 0};
	localparam int RX_IDLE [3] = '{80, 33, 0};

	// (first_data_block, block_count) per random setting; the last one is drawn at random
	localparam int unsigned SET_FIRST [NUM_SETTINGS] =
		'{0, 100, 16320, 108, 0, 16383, 1000, 0, 0};
	localparam int unsigned SET_COUNT [NUM_SETTINGS] =
		'{64, 164, 16384, 16384, 16384, 16384, 1040, 1, 0};

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              cfg_wr_en    = 1'b0;
	logic [0:0]        cfg_index    = '0;
	logic [CFG_W-1:0]  cfg_data     = '0;
	logic              in_valid     = 1'b0;
	logic              in_ready;
	logic [1:0]        command      = '0;
	logic [BN_W-1:0]   block_number = '0;
	logic              out_valid;
	logic              out_ready    = 1'b0;
	logic [BN_W-1:0]   result_block;
	logic              block_used;
	logic [1:0]        status;

	int fail_count;
	int pending;
	int checked;
	int tx_idle_pct = TX_IDLE[0];
	int rx_idle_pct = RX_IDLE[0];
	int requests_sent = 0;
	int settings_used = 1;
	int stall_cycles  = 0;

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	bitmap_block_allocator_core #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.WORD_BITS  (32)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.block_number (block_number),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_block (result_block),
		.block_used   (block_used),
		.status       (status)
	);

	bba_checker #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.WORD_BITS  (32)
	) checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.block_number (block_number),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_block (result_block),
		.block_used   (block_used),
		.status       (status),
		.fail_count   (fail_count),
		.pending      (pending),
		.checked      (checked)
	);

	// receiver backpressure, random per cycle according to the current plan
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99, 0) >= rx_idle_pct);
	end

	// watchdog: nothing moving on either channel for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// one request: optional idle gap, then hold valid until the block takes it
	task automatic send_request(input logic [1:0] cmd, input logic [BN_W-1:0] blk);
		int gap;
		gap = 0;
		while ($urandom_range(99, 0) < tx_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		command      <= cmd;
		block_number <= blk;
		do @(posedge clk); while (!in_ready);
		requests_sent++;
	endtask

	// wait until every request has its result, let the block settle, then write both registers
	task automatic set_config(input int unsigned first, input int unsigned count);
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (8) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= bba_pkg::CFG_FIRST_DATA_BLOCK;
		cfg_data  <= CFG_W'(first);
		@(posedge clk);
		cfg_index <= bba_pkg::CFG_BLOCK_COUNT;
		cfg_data  <= CFG_W'(count);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// mostly requests aimed at the allocation window, some anywhere in range,
	// some fully random block numbers (can be out of range, every bit toggled)
	task automatic send_random(input int unsigned first, input int unsigned count);
		int unsigned     pick;
		int unsigned     hi;
		logic [1:0]      cmd;
		logic [BN_W-1:0] blk;
		hi   = (count > MAX_BLOCKS) ? MAX_BLOCKS : count;
		pick = $urandom_range(99, 0);
		if (pick < 40)
			cmd = bba_pkg::CMD_ALLOC;
		else if (pick < 70)
			cmd = bba_pkg::CMD_FREE;
		else if (pick < 95)
			cmd = bba_pkg::CMD_TEST;
		else
			cmd = CMD_UNUSED;
		pick = $urandom_range(99, 0);
		if (pick < 60 && first < hi)
			blk = BN_W'($urandom_range(hi - 1, first));
		else if (pick < 80 && hi > 0)
			blk = BN_W'($urandom_range(hi - 1, 0));
		else
			blk = BN_W'($urandom());
		send_request(cmd, blk);
	endtask

	initial begin
		int unsigned first;
		int unsigned count;
		int          directed;

		// reset once, then the block runs its clearing pass with in_ready low
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed part at reset settings: first block 108, 16384 blocks
		send_request(bba_pkg::CMD_TEST, 14'd0);
		send_request(bba_pkg::CMD_ALLOC, 14'd16383);     // allocate ignores the block number
		send_request(bba_pkg::CMD_TEST, 14'd108);
		send_request(bba_pkg::CMD_ALLOC, 14'd0);
		send_request(bba_pkg::CMD_FREE, 14'd108);
		send_request(bba_pkg::CMD_FREE, 14'd108);        // freeing a free block is fine
		send_request(CMD_UNUSED, 14'd16383);             // unused code acts as test
		send_request(bba_pkg::CMD_FREE, 14'd16383);
		send_request(bba_pkg::CMD_ALLOC, 14'd0);         // lowest free again

		// tiny map: fill it, then run out of blocks
		set_config(0, 3);
		settings_used++;
		send_request(bba_pkg::CMD_ALLOC, 14'd0);
		send_request(bba_pkg::CMD_ALLOC, 14'd0);
		send_request(bba_pkg::CMD_ALLOC, 14'd0);
		send_request(bba_pkg::CMD_ALLOC, 14'd0);
		send_request(bba_pkg::CMD_FREE, 14'd3);          // free out of range
		send_request(bba_pkg::CMD_TEST, 14'd16383);      // test out of range
		send_request(CMD_UNUSED, 14'd3);
		send_request(bba_pkg::CMD_TEST, 14'd2);
		send_request(bba_pkg::CMD_FREE, 14'd1);
		send_request(bba_pkg::CMD_ALLOC, 14'd0);

		// empty allocation window: first block at the count
		set_config(5, 5);
		settings_used++;
		send_request(bba_pkg::CMD_ALLOC, 14'd0);

		// zero blocks: nothing is in range
		set_config(0, 0);
		settings_used++;
		send_request(bba_pkg::CMD_TEST, 14'd0);
		send_request(bba_pkg::CMD_ALLOC, 14'd0);
		send_request(bba_pkg::CMD_FREE, 14'd0);

		// count above the map size is clipped; highest first block
		set_config(16383, 32767);
		settings_used++;
		send_request(bba_pkg::CMD_ALLOC, 14'd0);
		send_request(bba_pkg::CMD_ALLOC, 14'd0);
		send_request(bba_pkg::CMD_TEST, 14'd16383);
		directed = requests_sent;

		// random part: three idle plans, three settings each
		for (int p = 0; p < NUM_SETTINGS; p++) begin
			tx_idle_pct <= TX_IDLE[p / 3];
			rx_idle_pct <= RX_IDLE[p / 3];
			if (p == NUM_SETTINGS - 1) begin
				first = $urandom_range(16383, 0);
				count = $urandom_range(16384, 1);
			end else begin
				first = SET_FIRST[p];
				count = SET_COUNT[p];
			end
			set_config(first, count);
			settings_used++;
			repeat (ITEMS_PER_SETTING)
				send_random(first, count);
		end

		// drain: every result back, then a little slack for stray outputs
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d requests (%0d directed) over %0d allocator settings",
			requests_sent, directed, settings_used);
		$display("%0d results compared under three sender/receiver idle plans", checked);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

>>> files.f
+incdir+src
src/bba_pkg.sv
src/bba_ram.sv
src/bba_div.sv
src/bitmap_block_allocator_core.sv
tb/bba_checker.sv
tb/testbench.sv
